[src/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // Default depth of the queue between classifier and emitter.
   localparam int QUEUE_DEPTH = 4;

   // Number of output bytes one input byte can produce.
   localparam int MAX_OUT = 3;

   // One classified input byte: up to three bytes to emit, in slot order.
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] data;
      logic [1:0]              count;
      logic                    last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h61) begin
         v = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41) begin
         v = c - 8'h41 + 8'd10;
      end else begin
         v = c - 8'h30;
      end
      hex_value = v[3:0];
   endfunction

endpackage

[src/upd_if.sv]
// ----------------------------------------------------------------------------
// upd_req_if / upd_rsp_if
// Valid/ready channels for encoded input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[src/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder: "%hh" becomes one byte, '+' becomes space.
// ----------------------------------------------------------------------------
//
//   channel    direction  payload              per transfer
//   req_chan   in         in_byte, in_last     one encoded byte
//   rsp_chan   out        out_byte, out_last   one decoded byte
//
// Takes one encoded byte per cycle, bounded by the single output byte port;
// an invalid escape emits up to three bytes for one input and slows the
// input only once the queue fills.
// A result is registered in the queue and then in the emitter before output.
// Synchronous reset drops any held escape and empties the queue.
// Either side may stall freely; the queue decouples them.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
   // Queue entries between classifier and emitter, 1 or more.
   parameter int QueueDepth = upd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   upd_req_if.sink    req_chan,
   upd_rsp_if.source  rsp_chan
);

   // Classified entry headed for the queue.
   upd_pkg::slot_type push;
   // Oldest queued entry, offered to the emitter.
   upd_pkg::slot_type head;
   logic              queue_room;
   logic              pop;

   // Track the escape state and pack each byte's results into one entry.
   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_room (queue_room),
      .push       (push)
   );

   // Hold entries so a stalled output blocks the input only once the queue fills.
   upd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (queue_room),
      .head  (head),
      .pop   (pop)
   );

   // Advance through each entry one output transfer at a time.
   upd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[src/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front
// Escape tracker: takes encoded bytes and turns them into queue entries.
// ----------------------------------------------------------------------------
module upd_front (
   input  logic               clock,
   input  logic               reset,
   upd_req_if.sink            req_chan,
   input  logic               queue_room,
   output upd_pkg::slot_type  push
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PCT   = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;
   logic               accept;
   logic               fresh_emit;
   logic [7:0]         fresh_byte;
   logic [7:0]         b;
   upd_pkg::entry_type entry;

   assign b          = req_chan.in_byte;
   assign accept     = req_chan.valid && queue_room;
   assign fresh_emit = !(b == upd_pkg::CH_PERCENT && !req_chan.in_last);
   assign fresh_byte = (b == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : b;

   always_comb begin
      entry       = '0;
      entry.last  = req_chan.in_last;
      phase_in    = phase_ff;
      held_in     = held_ff;
      case (phase_ff)
         PH_PCT: begin
            if (upd_pkg::is_hex(b)) begin
               if (req_chan.in_last) begin
                  entry.data[0] = upd_pkg::CH_PERCENT;
                  entry.data[1] = b;
                  entry.count   = 2'd2;
                  phase_in      = PH_IDLE;
               end else begin
                  held_in  = b;
                  phase_in = PH_DIGIT;
               end
            end else begin
               entry.data[0] = upd_pkg::CH_PERCENT;
               entry.data[1] = fresh_byte;
               entry.count   = fresh_emit ? 2'd2 : 2'd1;
               phase_in      = fresh_emit ? PH_IDLE : PH_PCT;
            end
         end
         PH_DIGIT: begin
            if (upd_pkg::is_hex(b)) begin
               entry.data[0] = {upd_pkg::hex_value(held_ff), upd_pkg::hex_value(b)};
               entry.count   = 2'd1;
               phase_in      = PH_IDLE;
            end else begin
               entry.data[0] = upd_pkg::CH_PERCENT;
               entry.data[1] = held_ff;
               entry.data[2] = fresh_byte;
               entry.count   = fresh_emit ? 2'd3 : 2'd2;
               phase_in      = fresh_emit ? PH_IDLE : PH_PCT;
            end
         end
         default: begin
            entry.data[0] = fresh_byte;
            entry.count   = fresh_emit ? 2'd1 : 2'd0;
            phase_in      = fresh_emit ? PH_IDLE : PH_PCT;
         end
      endcase
   end

   assign req_chan.ready = queue_room;
   assign push.valid     = accept && (entry.count != 2'd0);
   assign push.entry     = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

`ifndef SYNTHESIS
   // A message end always leaves nothing held.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.in_last |=> phase_ff == PH_IDLE)
      else $error("held bytes survived message end");
`endif

endmodule

[src/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue
// Small entry queue between the escape tracker and the byte emitter.
// ----------------------------------------------------------------------------
module upd_queue #(
   parameter int Depth = upd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  upd_pkg::slot_type  push,
   output logic               room,
   output upd_pkg::slot_type  head,
   input  logic               pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   upd_pkg::entry_type mem_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign room       = count_ff != CntW'(Depth);
   assign head.valid = count_ff != '0;
   assign head.entry = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && room;
   assign do_pop  = pop && head.valid;

   assign wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in  = count_ff + CntW'(do_push) - CntW'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> room)
      else $error("entry pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue occupancy out of range");
`endif

endmodule

[src/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back
// Byte emitter: unpacks queued entries into single output byte transfers.
// ----------------------------------------------------------------------------
module upd_back (
   input  logic               clock,
   input  logic               reset,
   input  upd_pkg::slot_type  head,
   output logic               pop,
   upd_rsp_if.source          rsp_chan
);

   upd_pkg::entry_type cur_ff;
   logic               busy_ff, busy_in;
   logic [1:0]         idx_ff, idx_in;
   logic               on_final;
   logic               xfer;

   assign on_final = idx_ff == (cur_ff.count - 2'd1);
   assign xfer     = rsp_chan.valid && rsp_chan.ready;
   assign pop      = head.valid && (!busy_ff || (xfer && on_final));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (xfer) begin
         if (on_final) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head.entry;
      end
   end

   assign rsp_chan.valid    = busy_ff;
   assign rsp_chan.out_byte = cur_ff.data[idx_ff];
   assign rsp_chan.out_last = cur_ff.last && on_final;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.count != 2'd0) && (idx_ff < cur_ff.count))
      else $error("emitter slot index beyond entry");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !rsp_chan.ready |=> busy_ff && $stable(idx_ff))
      else $error("emitter advanced while stalled");
`endif

endmodule
